// ===== design/rlse_pkg.sv =====
// Shared constants, types and sign-magnitude helpers for the line-shape evaluator.
package rlse_pkg;

  localparam int DW    = 48;
  localparam int FB    = 32;
  localparam int RW    = 2 * DW;
  localparam int HW    = DW / 2;
  localparam int MW    = DW - 1;
  localparam int NCELL = DW;
  localparam int IDXW  = 3;

  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] LIMU = {DW{1'b1}};
  localparam logic [DW-1:0] ONE  = {{(DW-1){1'b0}}, 1'b1} << FB;

  localparam logic [63:0] TWOPI_Q61 = 64'hC90FDAA22168C235;
  localparam logic [63:0] TWOPI_RND = (TWOPI_Q61 + (64'd1 << (60 - FB))) >> (61 - FB);
  localparam logic [DW-1:0] TWOPI  = (TWOPI_RND > 64'(MAXV)) ? MAXV : DW'(TWOPI_RND);

  typedef enum logic [IDXW-1:0] {
    CFG_GR  = 3'd0,
    CFG_GI  = 3'd1,
    CFG_THR = 3'd2,
    CFG_MU  = 3'd3,
    CFG_W   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic          ov;
    logic          n;
    logic [DW-1:0] m;
  } sm_t;

  typedef struct packed {
    logic          vld;
    logic          ov;
    logic          sn;
    logic          sat;
    logic [DW-1:0] mag;
  } side_t;

  typedef struct packed {
    logic          sat;
    logic [DW-1:0] rem;
    logic [DW-1:0] low;
  } dpre_t;

  function automatic sm_t sm_mk(input logic [DW:0] v, input logic n, input logic ov);
    sm_t r;
    if (v > {1'b0, MAXV}) begin
      r.m  = MAXV;
      r.ov = 1'b1;
    end else begin
      r.m  = v[DW-1:0];
      r.ov = ov;
    end
    r.n = n && (r.m != '0);
    return r;
  endfunction

  function automatic sm_t sm_from(input logic [DW-1:0] raw);
    sm_t r;
    r.ov = 1'b0;
    r.n  = raw[DW-1];
    r.m  = raw[DW-1] ? DW'(~raw + DW'(1)) : raw;
    return r;
  endfunction

  function automatic sm_t sm_neg(input sm_t a);
    sm_t r;
    r   = a;
    r.n = !a.n && (a.m != '0);
    return r;
  endfunction

  function automatic sm_t sm_add(input sm_t a, input sm_t b);
    logic ov;
    sm_t  r;
    ov = a.ov | b.ov;
    if (a.n == b.n) begin
      r = sm_mk({1'b0, a.m} + {1'b0, b.m}, a.n, ov);
    end else if (a.m >= b.m) begin
      r = sm_mk({1'b0, a.m - b.m}, a.n, ov);
    end else begin
      r = sm_mk({1'b0, b.m - a.m}, b.n, ov);
    end
    return r;
  endfunction

  function automatic sm_t sm_mulq(input logic [RW-1:0] p, input logic n, input logic ov);
    logic [RW-1:0] sh;
    sm_t           r;
    sh = p >> FB;
    if (sh[RW-1:DW-1] != '0) begin
      r.m  = MAXV;
      r.ov = 1'b1;
    end else begin
      r.m  = sh[DW-1:0];
      r.ov = ov;
    end
    r.n = n && (r.m != '0);
    return r;
  endfunction

  function automatic dpre_t dv_pre(input logic [DW-1:0] a, input logic [DW-1:0] b);
    dpre_t r;
    r.rem = a >> (DW - FB);
    r.sat = (b == '0) || (r.rem >= b);
    r.low = a << FB;
    return r;
  endfunction

  function automatic sm_t dv_post(input logic [DW-1:0] q, input logic sat,
                                  input logic [DW-1:0] lim, input logic n, input logic ov);
    sm_t r;
    if (sat || (q > lim)) begin
      r.m  = lim;
      r.ov = 1'b1;
    end else begin
      r.m  = q;
      r.ov = ov;
    end
    r.n = n && (r.m != '0);
    return r;
  endfunction

endpackage

// ===== design/rlse_mul.sv =====
// Two-stage multiplier built from four half-width partial products.
module rlse_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [rlse_pkg::DW-1:0]     a_i,
  input  logic [rlse_pkg::DW-1:0]     b_i,
  input  rlse_pkg::side_t             side_i,
  output logic [rlse_pkg::RW-1:0]     p_o,
  output rlse_pkg::side_t             side_o
);

  logic [rlse_pkg::DW-1:0] pp00_q, pp01_q, pp10_q, pp11_q;
  logic [rlse_pkg::DW:0]   mid;
  logic [rlse_pkg::RW-1:0] p_d;
  rlse_pkg::side_t         side_q;

  assign mid = {1'b0, pp01_q} + {1'b0, pp10_q};
  assign p_d = {pp11_q, pp00_q} + (rlse_pkg::RW'(mid) << rlse_pkg::HW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
      side_o <= '0;
    end else if (en_i) begin
      side_q <= side_i;
      side_o <= side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp00_q <= a_i[rlse_pkg::HW-1:0] * b_i[rlse_pkg::HW-1:0];
      pp01_q <= a_i[rlse_pkg::HW-1:0] * b_i[rlse_pkg::DW-1:rlse_pkg::HW];
      pp10_q <= a_i[rlse_pkg::DW-1:rlse_pkg::HW] * b_i[rlse_pkg::HW-1:0];
      pp11_q <= a_i[rlse_pkg::DW-1:rlse_pkg::HW] * b_i[rlse_pkg::DW-1:rlse_pkg::HW];
      p_o    <= p_d;
    end
  end

endmodule

// ===== design/rlse_sqrt_cell.sv =====
// One root digit of a digit-recurrence integer square root.
module rlse_sqrt_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [rlse_pkg::RW-1:0]   rad_i,
  input  logic [rlse_pkg::DW-1:0]   root_i,
  input  logic [rlse_pkg::DW+1:0]   rem_i,
  input  rlse_pkg::side_t           side_i,
  output logic [rlse_pkg::RW-1:0]   rad_o,
  output logic [rlse_pkg::DW-1:0]   root_o,
  output logic [rlse_pkg::DW+1:0]   rem_o,
  output rlse_pkg::side_t           side_o
);

  logic [rlse_pkg::DW+3:0] r4;
  logic [rlse_pkg::DW+3:0] trial;
  logic [rlse_pkg::DW+3:0] diff;
  logic                    ge;

  assign r4    = {rem_i, rad_i[rlse_pkg::RW-1 -: 2]};
  assign trial = {2'b00, root_i, 2'b01};
  assign diff  = r4 - trial;
  assign ge    = r4 >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_o <= '0;
    end else if (en_i) begin
      side_o <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= rad_i << 2;
      root_o <= {root_i[rlse_pkg::DW-2:0], ge};
      rem_o  <= ge ? diff[rlse_pkg::DW+1:0] : r4[rlse_pkg::DW+1:0];
    end
  end

endmodule

// ===== design/rlse_div_cell.sv =====
// One quotient bit of a restoring divider.
module rlse_div_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [rlse_pkg::DW-1:0]   div_i,
  input  logic [rlse_pkg::DW-1:0]   rem_i,
  input  logic [rlse_pkg::DW-1:0]   num_i,
  input  logic [rlse_pkg::DW-1:0]   quo_i,
  input  rlse_pkg::side_t           side_i,
  output logic [rlse_pkg::DW-1:0]   div_o,
  output logic [rlse_pkg::DW-1:0]   rem_o,
  output logic [rlse_pkg::DW-1:0]   num_o,
  output logic [rlse_pkg::DW-1:0]   quo_o,
  output rlse_pkg::side_t           side_o
);

  logic [rlse_pkg::DW:0] rem_sh;
  logic [rlse_pkg::DW:0] diff;
  logic                  ge;

  assign rem_sh = {rem_i, num_i[rlse_pkg::DW-1]};
  assign diff   = rem_sh - {1'b0, div_i};
  assign ge     = rem_sh >= {1'b0, div_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_o <= '0;
    end else if (en_i) begin
      side_o <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_o <= div_i;
      rem_o <= ge ? diff[rlse_pkg::DW-1:0] : rem_sh[rlse_pkg::DW-1:0];
      num_o <= num_i << 1;
      quo_o <= {quo_i[rlse_pkg::DW-2:0], ge};
    end
  end

endmodule

// ===== design/resonance_line_shape_eval_unit.sv =====
// Top level of the resonance line-shape evaluator.
// Throughput: one word per cycle while the output word is not held;
// the chains of root and divider cells set the depth.
// The whole item pipeline stalls only while the output word waits.
// Values derived from configuration alone settle in a free-running lane after a write.
// Reset clears all configuration registers to zero and empties the pipeline.
module resonance_line_shape_eval_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rlse_pkg::IDXW-1:0]     cfg_idx_i,
  input  logic [rlse_pkg::DW-1:0]       cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rlse_pkg::DW-1:0]       s_axis_tdata,   // [47:0] mass_in
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rlse_pkg::DW-1:0]       m_axis_tdata,   // [47:0] density
  output logic                          m_axis_tuser    // [0] overflow_flag
);

  localparam int N = rlse_pkg::NCELL;

  logic [rlse_pkg::DW-1:0] gr_q, gi_q, thr_q;
  logic [rlse_pkg::MW-1:0] mu_q, w_q;
  logic [rlse_pkg::DW-1:0] mu_m;
  rlse_pkg::sm_t           gr_s, gi_s, thr_s, w_s;
  logic                    en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gr_q  <= '0;
      gi_q  <= '0;
      thr_q <= '0;
      mu_q  <= '0;
      w_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (rlse_pkg::cfg_idx_e'(cfg_idx_i))
        rlse_pkg::CFG_GR:  gr_q  <= cfg_data_i;
        rlse_pkg::CFG_GI:  gi_q  <= cfg_data_i;
        rlse_pkg::CFG_THR: thr_q <= cfg_data_i;
        rlse_pkg::CFG_MU:  mu_q  <= cfg_data_i[rlse_pkg::MW-1:0];
        rlse_pkg::CFG_W:   w_q   <= cfg_data_i[rlse_pkg::MW-1:0];
        default: ;
      endcase
    end
  end

  assign gr_s  = rlse_pkg::sm_from(gr_q);
  assign gi_s  = rlse_pkg::sm_from(gi_q);
  assign thr_s = rlse_pkg::sm_from(thr_q);
  assign mu_m  = {1'b0, mu_q};
  assign w_s   = '{ov: 1'b0, n: 1'b0, m: {1'b0, w_q}};

  // free-running lane for values that depend on configuration only
  logic [rlse_pkg::RW-1:0] p_wmu, p_grgi, p_mu2, p_gr2, p_gi2, p_ci2, p_bot, p_mg;
  rlse_pkg::sm_t           ci_s, t2, tt2, gxd, gx, mu2, mg, gr2, gi2, sg, bot;
  rlse_pkg::dpre_t         gpre;
  logic                    ov_cfg;

  rlse_mul u_c_wmu  (.clk_i, .rst_ni, .en_i(1'b1), .a_i({1'b0, w_q}), .b_i(mu_m),
                     .side_i('0), .p_o(p_wmu), .side_o());
  rlse_mul u_c_grgi (.clk_i, .rst_ni, .en_i(1'b1), .a_i(gr_s.m), .b_i(gi_s.m),
                     .side_i('0), .p_o(p_grgi), .side_o());
  rlse_mul u_c_mu2  (.clk_i, .rst_ni, .en_i(1'b1), .a_i(mu_m), .b_i(mu_m),
                     .side_i('0), .p_o(p_mu2), .side_o());
  rlse_mul u_c_gr2  (.clk_i, .rst_ni, .en_i(1'b1), .a_i(gr_s.m), .b_i(gr_s.m),
                     .side_i('0), .p_o(p_gr2), .side_o());
  rlse_mul u_c_gi2  (.clk_i, .rst_ni, .en_i(1'b1), .a_i(gi_s.m), .b_i(gi_s.m),
                     .side_i('0), .p_o(p_gi2), .side_o());
  rlse_mul u_c_ci2  (.clk_i, .rst_ni, .en_i(1'b1), .a_i(ci_s.m), .b_i(ci_s.m),
                     .side_i('0), .p_o(p_ci2), .side_o());
  rlse_mul u_c_bot  (.clk_i, .rst_ni, .en_i(1'b1), .a_i(rlse_pkg::TWOPI), .b_i(sg.m),
                     .side_i('0), .p_o(p_bot), .side_o());
  rlse_mul u_c_mg   (.clk_i, .rst_ni, .en_i(1'b1), .a_i(mu2.m), .b_i(gx.m),
                     .side_i('0), .p_o(p_mg), .side_o());

  assign ci_s = rlse_pkg::sm_neg(rlse_pkg::sm_mulq(p_wmu, 1'b0, 1'b0));
  assign t2   = rlse_pkg::sm_mulq(p_grgi, gr_s.n ^ gi_s.n, 1'b0);
  assign tt2  = rlse_pkg::sm_add(t2, t2);
  assign gpre = rlse_pkg::dv_pre(tt2.m, mu_m);
  assign mu2  = rlse_pkg::sm_mulq(p_mu2, 1'b0, 1'b0);
  assign gr2  = rlse_pkg::sm_mulq(p_gr2, 1'b0, 1'b0);
  assign gi2  = rlse_pkg::sm_mulq(p_gi2, 1'b0, 1'b0);
  assign sg   = rlse_pkg::sm_add(gr2, gi2);
  assign bot  = rlse_pkg::sm_mulq(p_bot, 1'b0, sg.ov);
  assign gx   = rlse_pkg::sm_add(w_s, gxd);
  assign mg   = rlse_pkg::sm_mulq(p_mg, gx.n, gx.ov | mu2.ov);
  assign ov_cfg = ci_s.ov | mg.ov | bot.ov;

  // item lane
  logic                    v0_q;
  logic [rlse_pkg::DW-1:0] x_q;
  logic                    out_vld_q;
  logic [rlse_pkg::DW-1:0] dens_q;
  logic                    flag_q;
  rlse_pkg::sm_t           e, t, tt, cr, sr_s, si_s, dr, di, f, top, res;
  rlse_pkg::side_t         sd1, sd2, sd3, sd5;
  logic [rlse_pkg::RW-1:0] p1, p2, p3, p4, p5;
  logic [rlse_pkg::DW-1:0] hp, hm, sr, si, nq_m;
  logic [rlse_pkg::RW:0]   sq;
  logic                    nq_ov;
  rlse_pkg::dpre_t         fpre, dpre;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= s_axis_tdata;
    end
  end

  assign e = rlse_pkg::sm_add(rlse_pkg::sm_from(x_q), rlse_pkg::sm_neg(thr_s));

  rlse_mul u_mul_t (.clk_i, .rst_ni, .en_i(en), .a_i(mu_m), .b_i(e.m),
                    .side_i('{vld: v0_q, ov: e.ov, sn: e.n, sat: 1'b0, mag: '0}),
                    .p_o(p1), .side_o(sd1));

  assign t  = rlse_pkg::sm_mulq(p1, sd1.sn, sd1.ov);
  assign tt = rlse_pkg::sm_add(t, t);
  assign cr = rlse_pkg::sm_neg(tt);

  rlse_mul u_mul_cr (.clk_i, .rst_ni, .en_i(en), .a_i(cr.m), .b_i(cr.m),
                     .side_i('{vld: sd1.vld, ov: cr.ov, sn: cr.n, sat: 1'b0, mag: cr.m}),
                     .p_o(p2), .side_o(sd2));

  // square-root rows: modulus, then its half-sum and half-difference
  logic [rlse_pkg::RW-1:0]  a_rad  [0:N];
  logic [rlse_pkg::DW-1:0]  a_root [0:N];
  logic [rlse_pkg::DW+1:0]  a_rem  [0:N];
  rlse_pkg::side_t          a_sd   [0:N];
  logic [rlse_pkg::RW-1:0]  b_rad  [0:N];
  logic [rlse_pkg::DW-1:0]  b_root [0:N];
  logic [rlse_pkg::DW+1:0]  b_rem  [0:N];
  rlse_pkg::side_t          b_sd   [0:N];
  logic [rlse_pkg::RW-1:0]  c_rad  [0:N];
  logic [rlse_pkg::DW-1:0]  c_root [0:N];
  logic [rlse_pkg::DW+1:0]  c_rem  [0:N];

  assign a_rad[0]  = p2 + p_ci2;
  assign a_root[0] = '0;
  assign a_rem[0]  = '0;
  assign a_sd[0]   = sd2;

  assign hp = (a_root[N] >> 1) + (a_sd[N].mag >> 1) +
              rlse_pkg::DW'(a_root[N][0] & a_sd[N].mag[0]);
  assign hm = (a_root[N] - a_sd[N].mag) >> 1;

  assign b_rad[0]  = rlse_pkg::RW'(hp) << rlse_pkg::FB;
  assign b_root[0] = '0;
  assign b_rem[0]  = '0;
  assign b_sd[0]   = a_sd[N];
  assign c_rad[0]  = rlse_pkg::RW'(hm) << rlse_pkg::FB;
  assign c_root[0] = '0;
  assign c_rem[0]  = '0;

  // divider rows: coupling ratio (free-running), reciprocal, final quotient
  logic [rlse_pkg::DW-1:0]  g_div [0:N], g_rem [0:N], g_num [0:N], g_quo [0:N];
  rlse_pkg::side_t          g_sd  [0:N];
  logic [rlse_pkg::DW-1:0]  f_div [0:N], f_rem [0:N], f_num [0:N], f_quo [0:N];
  rlse_pkg::side_t          f_sd  [0:N];
  logic [rlse_pkg::DW-1:0]  d_div [0:N], d_rem [0:N], d_num [0:N], d_quo [0:N];
  rlse_pkg::side_t          d_sd  [0:N];

  assign g_div[0] = mu_m;
  assign g_rem[0] = gpre.rem;
  assign g_num[0] = gpre.low;
  assign g_quo[0] = '0;
  assign g_sd[0]  = '{vld: 1'b1, ov: tt2.ov, sn: tt2.n, sat: gpre.sat, mag: '0};
  assign gxd = rlse_pkg::dv_post(g_quo[N], g_sd[N].sat, rlse_pkg::MAXV,
                                 g_sd[N].sn, g_sd[N].ov);

  genvar i;
  for (i = 0; i < N; i++) begin : g_cell
    rlse_sqrt_cell u_sqa (.clk_i, .rst_ni, .en_i(en),
      .rad_i(a_rad[i]), .root_i(a_root[i]), .rem_i(a_rem[i]), .side_i(a_sd[i]),
      .rad_o(a_rad[i+1]), .root_o(a_root[i+1]), .rem_o(a_rem[i+1]), .side_o(a_sd[i+1]));
    rlse_sqrt_cell u_sqb (.clk_i, .rst_ni, .en_i(en),
      .rad_i(b_rad[i]), .root_i(b_root[i]), .rem_i(b_rem[i]), .side_i(b_sd[i]),
      .rad_o(b_rad[i+1]), .root_o(b_root[i+1]), .rem_o(b_rem[i+1]), .side_o(b_sd[i+1]));
    rlse_sqrt_cell u_sqc (.clk_i, .rst_ni, .en_i(en),
      .rad_i(c_rad[i]), .root_i(c_root[i]), .rem_i(c_rem[i]), .side_i('0),
      .rad_o(c_rad[i+1]), .root_o(c_root[i+1]), .rem_o(c_rem[i+1]), .side_o());
    rlse_div_cell u_dvg (.clk_i, .rst_ni, .en_i(1'b1),
      .div_i(g_div[i]), .rem_i(g_rem[i]), .num_i(g_num[i]), .quo_i(g_quo[i]),
      .side_i(g_sd[i]), .div_o(g_div[i+1]), .rem_o(g_rem[i+1]), .num_o(g_num[i+1]),
      .quo_o(g_quo[i+1]), .side_o(g_sd[i+1]));
    rlse_div_cell u_dvf (.clk_i, .rst_ni, .en_i(en),
      .div_i(f_div[i]), .rem_i(f_rem[i]), .num_i(f_num[i]), .quo_i(f_quo[i]),
      .side_i(f_sd[i]), .div_o(f_div[i+1]), .rem_o(f_rem[i+1]), .num_o(f_num[i+1]),
      .quo_o(f_quo[i+1]), .side_o(f_sd[i+1]));
    rlse_div_cell u_dvd (.clk_i, .rst_ni, .en_i(en),
      .div_i(d_div[i]), .rem_i(d_rem[i]), .num_i(d_num[i]), .quo_i(d_quo[i]),
      .side_i(d_sd[i]), .div_o(d_div[i+1]), .rem_o(d_rem[i+1]), .num_o(d_num[i+1]),
      .quo_o(d_quo[i+1]), .side_o(d_sd[i+1]));
  end

  // principal root, then distance to the coupling
  assign sr   = b_sd[N].sn ? c_root[N] : b_root[N];
  assign si   = b_sd[N].sn ? b_root[N] : c_root[N];
  assign sr_s = '{ov: 1'b0, n: 1'b0, m: sr};
  assign si_s = '{ov: 1'b0, n: ci_s.n && (si != '0), m: si};
  assign dr   = rlse_pkg::sm_add(sr_s, rlse_pkg::sm_neg(gr_s));
  assign di   = rlse_pkg::sm_add(si_s, rlse_pkg::sm_neg(gi_s));

  rlse_mul u_mul_dr (.clk_i, .rst_ni, .en_i(en), .a_i(dr.m), .b_i(dr.m),
                     .side_i('{vld: b_sd[N].vld, ov: b_sd[N].ov | dr.ov | di.ov,
                               sn: 1'b0, sat: 1'b0, mag: '0}),
                     .p_o(p3), .side_o(sd3));
  rlse_mul u_mul_di (.clk_i, .rst_ni, .en_i(en), .a_i(di.m), .b_i(di.m),
                     .side_i('0), .p_o(p4), .side_o());

  assign sq    = ({1'b0, p3} + {1'b0, p4}) >> rlse_pkg::FB;
  assign nq_ov = sq[rlse_pkg::RW:rlse_pkg::DW-1] != '0;
  assign nq_m  = nq_ov ? rlse_pkg::MAXV : sq[rlse_pkg::DW-1:0];
  assign fpre  = rlse_pkg::dv_pre(rlse_pkg::ONE, nq_m);

  assign f_div[0] = nq_m;
  assign f_rem[0] = fpre.rem;
  assign f_num[0] = fpre.low;
  assign f_quo[0] = '0;
  assign f_sd[0]  = '{vld: sd3.vld, ov: sd3.ov | nq_ov, sn: 1'b0, sat: fpre.sat, mag: '0};
  assign f = rlse_pkg::dv_post(f_quo[N], f_sd[N].sat, rlse_pkg::MAXV, 1'b0, f_sd[N].ov);

  rlse_mul u_mul_top (.clk_i, .rst_ni, .en_i(en), .a_i(mg.m), .b_i(f.m),
                      .side_i('{vld: f_sd[N].vld, ov: f.ov, sn: mg.n, sat: 1'b0, mag: '0}),
                      .p_o(p5), .side_o(sd5));

  assign top  = rlse_pkg::sm_mulq(p5, sd5.sn, sd5.ov);
  assign dpre = rlse_pkg::dv_pre(top.m, bot.m);

  assign d_div[0] = bot.m;
  assign d_rem[0] = dpre.rem;
  assign d_num[0] = dpre.low;
  assign d_quo[0] = '0;
  assign d_sd[0]  = '{vld: sd5.vld, ov: top.ov, sn: top.n, sat: dpre.sat, mag: '0};
  assign res = rlse_pkg::dv_post(d_quo[N], d_sd[N].sat, rlse_pkg::LIMU,
                                 d_sd[N].sn, d_sd[N].ov);

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d_sd[N].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dens_q <= res.n ? '0 : res.m;
      flag_q <= res.ov | res.n | ov_cfg;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = dens_q;
  assign m_axis_tuser  = flag_q;

endmodule

// ===== design/rlse_checker.sv =====
// Port-level checks for the line-shape evaluator, bound to the top level.
module rlse_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [rlse_pkg::DW-1:0]   m_axis_tdata,
  input logic                      m_axis_tuser
);

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output word valid after reset");

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output word changed");

endmodule

bind resonance_line_shape_eval_unit rlse_checker u_rlse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/tb_resonance_line_shape_eval_unit.sv =====
// Self-checking testbench for the resonance line-shape evaluator, with a bit-exact density predictor.
module tb_resonance_line_shape_eval_unit;

  localparam logic [63:0] SAT_MAX  = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] SAT_FULL = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] TWO_PI_Q61 = 64'hC90FDAA22168C235;

  typedef struct {
    logic [63:0] m;
    bit          n;
  } smag_t;

  class density_scoreboard;
    bit          ovf;
    logic [47:0] gr_reg, gi_reg, thr_reg;
    logic [46:0] mu_reg, w_reg;
    logic [47:0] density_q[$];
    bit          flag_q[$];
    int          errors;

    function void set_reg(rlse_pkg::cfg_idx_e idx, logic [47:0] v);
      case (idx)
        rlse_pkg::CFG_GR:  gr_reg  = v;
        rlse_pkg::CFG_GI:  gi_reg  = v;
        rlse_pkg::CFG_THR: thr_reg = v;
        rlse_pkg::CFG_MU:  mu_reg  = v[46:0];
        rlse_pkg::CFG_W:   w_reg   = v[46:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] clip(logic [127:0] v, logic [63:0] lim);
      if (v > {64'b0, lim}) begin
        ovf = 1;
        return lim;
      end
      return v[63:0];
    endfunction

    function smag_t mk(logic [63:0] m, bit n);
      smag_t r;
      if (m > SAT_MAX) begin
        ovf = 1;
        m = SAT_MAX;
      end
      r.m = m;
      r.n = n && (m != 0);
      return r;
    endfunction

    function smag_t from_raw(logic [47:0] raw);
      smag_t       r;
      logic [47:0] mag;
      mag = raw[47] ? (~raw + 48'd1) : raw;
      r.m = {16'b0, mag};
      r.n = raw[47];
      return r;
    endfunction

    function smag_t neg(smag_t a);
      a.n = !a.n && (a.m != 0);
      return a;
    endfunction

    function smag_t add(smag_t a, smag_t b);
      if (a.n == b.n) return mk(a.m + b.m, a.n);
      if (a.m >= b.m) return mk(a.m - b.m, a.n);
      return mk(b.m - a.m, b.n);
    endfunction

    function smag_t mul(smag_t a, smag_t b);
      smag_t r;
      r.m = clip(({64'b0, a.m} * {64'b0, b.m}) >> rlse_pkg::FB, SAT_MAX);
      r.n = (a.n != b.n) && (r.m != 0);
      return r;
    endfunction

    function smag_t quot(smag_t a, smag_t b, logic [63:0] lim);
      smag_t r;
      if (b.m == 0) begin
        ovf = 1;
        r.m = lim;
        r.n = a.n;
        return r;
      end
      r.m = clip(({64'b0, a.m} << rlse_pkg::FB) / {64'b0, b.m}, lim);
      r.n = (a.n != b.n) && (r.m != 0);
      return r;
    endfunction

    function logic [63:0] isqrt(logic [127:0] v);
      logic [63:0] r, c;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if ({64'b0, c} * {64'b0, c} <= v) r = c;
      end
      return r;
    endfunction

    function logic [63:0] root_q(logic [63:0] u);
      return clip({64'b0, isqrt({64'b0, u} << rlse_pkg::FB)}, SAT_MAX);
    endfunction

    function void note_mass(logic [47:0] x_raw);
      smag_t       x, thr, gr, gi, mu, w, e, t, cr, ci, sr, si, dr, di, nq, one, f;
      smag_t       gx, top, bottom, res, tp;
      logic [63:0] m, hp, hm, p, q;
      ovf = 0;
      x   = from_raw(x_raw);
      thr = from_raw(thr_reg);
      gr  = from_raw(gr_reg);
      gi  = from_raw(gi_reg);
      mu  = mk({17'b0, mu_reg}, 0);
      w   = mk({17'b0, w_reg}, 0);
      e   = add(x, neg(thr));
      t   = mul(mu, e);
      cr  = neg(add(t, t));
      ci  = neg(mul(w, mu));
      m   = isqrt({64'b0, cr.m} * {64'b0, cr.m} + {64'b0, ci.m} * {64'b0, ci.m});
      hp  = (m >> 1) + (cr.m >> 1) + (m & cr.m & 64'd1);
      hm  = (m - cr.m) >> 1;
      p   = root_q(hp);
      q   = root_q(hm);
      sr  = mk(cr.n ? q : p, 0);
      si  = mk(cr.n ? p : q, ci.n);
      dr  = add(sr, neg(gr));
      di  = add(si, neg(gi));
      nq.m = clip(({64'b0, dr.m} * {64'b0, dr.m} + {64'b0, di.m} * {64'b0, di.m})
                  >> rlse_pkg::FB, SAT_MAX);
      nq.n = 0;
      one.m = 64'd1 << rlse_pkg::FB;
      one.n = 0;
      f   = quot(one, nq, SAT_MAX);
      t   = mul(gr, gi);
      gx  = add(w, quot(add(t, t), mu, SAT_MAX));
      top = mul(mul(mul(mu, mu), gx), f);
      tp.m = (TWO_PI_Q61 + (64'd1 << (60 - rlse_pkg::FB))) >> (61 - rlse_pkg::FB);
      if (tp.m > SAT_MAX) tp.m = SAT_MAX;
      tp.n = 0;
      bottom = mul(tp, add(mul(gr, gr), mul(gi, gi)));
      res = quot(top, bottom, SAT_FULL);
      if (res.n) begin
        ovf = 1;
        density_q.push_back(48'd0);
      end else begin
        density_q.push_back(res.m[47:0]);
      end
      flag_q.push_back(ovf);
    endfunction

    function void check_density(logic [47:0] dens, logic flag);
      logic [47:0] e_dens;
      bit          e_flag;
      if (density_q.size() == 0) begin
        $display("%0t: unexpected word density=%h flag=%b", $time, dens, flag);
        errors++;
        return;
      end
      e_dens = density_q.pop_front();
      e_flag = flag_q.pop_front();
      if (dens !== e_dens) begin
        $display("%0t: density mismatch expected=%h actual=%h", $time, e_dens, dens);
        errors++;
      end
      if (flag !== e_flag) begin
        $display("%0t: overflow flag mismatch expected=%b actual=%b", $time, e_flag, flag);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i = 0;
  logic                          rst_ni = 0;
  logic                          cfg_we_i = 0;
  logic [rlse_pkg::IDXW-1:0]     cfg_idx_i = '0;
  logic [rlse_pkg::DW-1:0]       cfg_data_i = '0;
  logic                          s_axis_tvalid = 0;
  logic                          s_axis_tready;
  logic [rlse_pkg::DW-1:0]       s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 0;
  logic [rlse_pkg::DW-1:0]       m_axis_tdata;
  logic                          m_axis_tuser;

  density_scoreboard sb = new();
  bit                long_hold_req = 0;

  resonance_line_shape_eval_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_density(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    int mode;
    forever begin
      if (long_hold_req) begin
        m_axis_tready <= 0;
        repeat (600) @(posedge clk_i);
        long_hold_req = 0;
      end
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(16, 80)) begin
        case (mode)
          0:       m_axis_tready <= 1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [47:0] rnd_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic logic [47:0] rnd_scaled();
    logic signed [47:0] v;
    v = rnd_word();
    return v >>> $urandom_range(0, 44);
  endfunction

  task automatic cfg_write(rlse_pkg::cfg_idx_e idx, logic [47:0] v);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    sb.set_reg(idx, v);
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic send_mass(logic [47:0] v);
    s_axis_tvalid <= 1;
    s_axis_tdata  <= v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_mass(v);
  endtask

  task automatic pause(int n);
    s_axis_tvalid <= 0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    pause(1);
    while (sb.density_q.size() != 0) @(posedge clk_i);
    pause(220);
  endtask

  task automatic load_config(logic [47:0] gr, logic [47:0] gi, logic [47:0] thr,
                             logic [47:0] mu, logic [47:0] w);
    cfg_write(rlse_pkg::CFG_GR, gr);
    cfg_write(rlse_pkg::CFG_GI, gi);
    cfg_write(rlse_pkg::CFG_THR, thr);
    cfg_write(rlse_pkg::CFG_MU, mu);
    cfg_write(rlse_pkg::CFG_W, w);
    pause(64);
  endtask

  task automatic random_masses(int n, bit no_gaps);
    int          left, burst;
    logic [47:0] v;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && left > 0) begin
        if ($urandom_range(0, 4) == 0) v = rnd_word();
        else v = sb.thr_reg + rnd_scaled();
        send_mass(v);
        burst--;
        left--;
      end
      if (!no_gaps && $urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // reset configuration: zero couplings force the divide-by-zero path
    send_mass(48'h0);
    send_mass(48'h7FFF_FFFF_FFFF);
    random_masses(60, 0);
    drain();

    load_config(48'h1_0000_0000, 48'h0_8000_0000, 48'h3_DEB8_51EC,
                48'h0_F851_EB85, 48'h0_0041_8937);
    send_mass(48'h0);
    send_mass(48'h7FFF_FFFF_FFFF);
    send_mass(48'h8000_0000_0000);
    send_mass(48'hFFFF_FFFF_FFFF);
    send_mass(48'h1);
    send_mass(sb.thr_reg);
    send_mass(sb.thr_reg + 48'd1);
    send_mass(sb.thr_reg - 48'd1);
    send_mass(sb.thr_reg + 48'h1_0000_0000);
    send_mass(sb.thr_reg - 48'h1_0000_0000);
    send_mass(sb.thr_reg + 48'h0_0100_0000);
    send_mass(sb.thr_reg - 48'h0_0100_0000);
    random_masses(150, 0);
    drain();

    load_config(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h8000_0000_0000,
                48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
    send_mass(48'h7FFF_FFFF_FFFF);
    send_mass(48'h8000_0000_0000);
    random_masses(120, 0);
    drain();

    // zero reduced mass and width
    load_config(48'h0, 48'h0_0010_0000, 48'hFFFF_0000_0000, 48'h0, 48'h0);
    random_masses(120, 0);
    drain();

    load_config(rnd_scaled(), rnd_scaled(), rnd_scaled(),
                rnd_scaled() & 48'h7FFF_FFFF_FFFF,
                rnd_scaled() & 48'h7FFF_FFFF_FFFF);
    long_hold_req = 1;
    random_masses(320, 1);
    drain();

    repeat (4) begin
      load_config(rnd_scaled(), rnd_scaled(), rnd_scaled(),
                  rnd_scaled() & 48'h7FFF_FFFF_FFFF,
                  rnd_scaled() & 48'h7FFF_FFFF_FFFF);
      random_masses(130, 0);
      drain();
    end

    if (sb.errors == 0 && sb.density_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
